// ----- hw/rtl/rtcf_pkg.sv -----
// rtcf_pkg: shared types and constants for the row top-two colour finder
// no dependencies; imported by row_top_two_color_finder
package rtcf_pkg;

    localparam int MAX_ROW_PIXELS = 2048;
    localparam int NUM_BINS       = 256;
    localparam int COLOR_W        = 8;
    localparam int COUNT_W        = 12;
    localparam int COUNT_MAX      = (1 << COUNT_W) - 1;

    // bin counts stop here
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        COUNT_W'((MAX_ROW_PIXELS > COUNT_MAX) ? COUNT_MAX : MAX_ROW_PIXELS);

    // colour code that stands for "no colour"
    localparam logic [COLOR_W-1:0] COLOR_NONE = '1;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel;
        logic               row_end;
    } pixel_in_t;

    typedef struct packed {
        logic [COLOR_W-1:0] main_color;
        logic [COLOR_W-1:0] second_color;
    } color_out_t;

    // one histogram entry: generation tag and count
    typedef struct packed {
        logic               gen;
        logic [COUNT_W-1:0] count;
    } bin_entry_t;

endpackage

// ----- hw/rtl/row_top_two_color_finder.sv -----
// row_top_two_color_finder: per-row leader and runner-up gray value from a histogram
// depends on rtcf_pkg (types, bin count cap)
//
//   channel | dir | payload              | transfer when
//   --------+-----+----------------------+---------------------
//   s_      | in  | pixel, row_end       | s_valid && s_ready
//   m_      | out | main_color, second   | m_valid && m_ready
//
// one pixel per cycle while no row-end pixel waits on a full output register; the
// histogram read-modify-write is split: read at transfer, modify and write from
// stage 1, with a one-deep forward for back-to-back hits
// a row result is registered in the output register when its row-end pixel
// leaves stage 1 and is then offered on m_
// reset: synchronous, active low; clears the bin valid flags and the trackers,
// no clearing pass (bins read as empty until written); a row end clears the flags
// stall: only a row-end pixel waiting on a full output register holds the input
module row_top_two_color_finder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rtcf_pkg::pixel_in_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rtcf_pkg::color_out_t m_data
);
    import rtcf_pkg::*;

    // histogram memory, one entry per gray value
    bin_entry_t          hist_mem [NUM_BINS];
    bin_entry_t          rd_entry_reg;
    logic [NUM_BINS-1:0] bin_valid_reg;

    // stage 1: item whose bin data is coming out of the memory
    logic               s1_valid_reg, s1_valid_next;
    logic [COLOR_W-1:0] s1_pixel_reg;
    logic               s1_row_end_reg;

    // forward of a write to the same bin in the read cycle
    logic       fwd_hit_reg, fwd_hit_next;
    bin_entry_t fwd_entry_reg;

    // running trackers and row generation
    logic               row_gen_reg, row_gen_next;
    logic [COLOR_W-1:0] lead_color_reg, lead_color_next;
    logic [COUNT_W-1:0] lead_count_reg, lead_count_next;
    logic [COLOR_W-1:0] run_color_reg, run_color_next;
    logic [COUNT_W-1:0] run_count_reg, run_count_next;

    // output register
    logic       m_valid_reg, m_valid_next;
    color_out_t m_data_reg;

    logic               s_fire;
    logic               s1_fire;
    bin_entry_t         src_entry;
    logic               entry_live;
    logic [COUNT_W-1:0] old_count;
    logic [COUNT_W-1:0] new_count;
    logic               saturated;
    logic               wr_en;
    bin_entry_t         wr_entry;
    logic [COLOR_W-1:0] upd_lead_color, upd_run_color;
    logic [COUNT_W-1:0] upd_lead_count, upd_run_count;

    // a row-end item moves only when the output register has room
    assign s1_fire = s1_valid_reg && (!s1_row_end_reg || !m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_fire;
    assign s_fire  = s_valid && s_ready;

    // old bin count: forwarded write wins over memory, stale tag reads as zero
    always_comb begin
        src_entry  = fwd_hit_reg ? fwd_entry_reg : rd_entry_reg;
        entry_live = (fwd_hit_reg || bin_valid_reg[s1_pixel_reg])
                     && (src_entry.gen == row_gen_reg);
        old_count  = entry_live ? src_entry.count : '0;
        saturated  = (old_count >= COUNT_CAP);
        new_count  = old_count + COUNT_W'(1);
        wr_en      = s1_fire && !saturated;
        wr_entry   = '{gen: row_gen_reg, count: new_count};
    end

    // tracker update from the new count
    always_comb begin
        upd_lead_color = lead_color_reg;
        upd_lead_count = lead_count_reg;
        upd_run_color  = run_color_reg;
        upd_run_count  = run_count_reg;
        if (!saturated) begin
            if (new_count > lead_count_reg) begin
                if (s1_pixel_reg != lead_color_reg) begin
                    upd_run_color  = lead_color_reg;
                    upd_run_count  = lead_count_reg;
                    upd_lead_color = s1_pixel_reg;
                end
                upd_lead_count = new_count;
            end else if (new_count > run_count_reg) begin
                upd_run_color = s1_pixel_reg;
                upd_run_count = new_count;
            end
        end
    end

    always_comb begin
        s1_valid_next   = s1_fire ? 1'b0 : s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end
        fwd_hit_next    = fwd_hit_reg;
        if (s_fire) begin
            fwd_hit_next = wr_en && (s1_pixel_reg == s_data.pixel);
        end else if (s1_fire) begin
            fwd_hit_next = 1'b0;
        end
        row_gen_next    = row_gen_reg;
        lead_color_next = lead_color_reg;
        lead_count_next = lead_count_reg;
        run_color_next  = run_color_reg;
        run_count_next  = run_count_reg;
        m_valid_next    = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        if (s1_fire) begin
            if (s1_row_end_reg) begin
                // row done: flip generation, empty the trackers
                row_gen_next    = !row_gen_reg;
                lead_color_next = COLOR_NONE;
                lead_count_next = '0;
                run_color_next  = COLOR_NONE;
                run_count_next  = '0;
                m_valid_next    = 1'b1;
            end else begin
                lead_color_next = upd_lead_color;
                lead_count_next = upd_lead_count;
                run_color_next  = upd_run_color;
                run_count_next  = upd_run_count;
            end
        end
    end

    // histogram memory: read at transfer, write from stage 1
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_entry_reg <= hist_mem[s_data.pixel];
        end
        if (wr_en) begin
            hist_mem[s1_pixel_reg] <= wr_entry;
        end
    end

    // per-bin written flags, emptied at every row end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_valid_reg <= '0;
        end else if (s1_fire && s1_row_end_reg) begin
            bin_valid_reg <= '0;
        end else if (wr_en) begin
            bin_valid_reg[s1_pixel_reg] <= 1'b1;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_pixel_reg   <= s_data.pixel;
            s1_row_end_reg <= s_data.row_end;
            fwd_entry_reg  <= wr_entry;
        end
        if (s1_fire && s1_row_end_reg) begin
            m_data_reg.main_color   <= upd_lead_color;
            m_data_reg.second_color <= upd_run_color;
        end
    end

    // control state and trackers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            row_gen_reg    <= 1'b0;
            lead_color_reg <= COLOR_NONE;
            lead_count_reg <= '0;
            run_color_reg  <= COLOR_NONE;
            run_count_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            s1_valid_reg   <= s1_valid_next;
            fwd_hit_reg    <= fwd_hit_next;
            row_gen_reg    <= row_gen_next;
            lead_color_reg <= lead_color_next;
            lead_count_reg <= lead_count_next;
            run_color_reg  <= run_color_next;
            run_count_reg  <= run_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // the leader never trails the runner-up
    assert property (@(posedge aclk) disable iff (!aresetn)
        lead_count_reg >= run_count_reg)
        else $error("leader count below runner-up count");

    // leader count stays within the bin cap
    assert property (@(posedge aclk) disable iff (!aresetn)
        lead_count_reg <= COUNT_CAP)
        else $error("leader count above cap");

    // a finished row always lands in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_row_end_reg) |=> m_valid_reg)
        else $error("row result lost");

    // trackers are empty after a row end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_row_end_reg) |=> (lead_count_reg == '0 && run_count_reg == '0))
        else $error("trackers not cleared at row end");

    // a forward only serves an item sitting in stage 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forward hit without stage 1 item");
`endif

endmodule
